FILE: hw/rtl/pmsdp_pkg.sv
`timescale 1ns / 1ps
package pmsdp_pkg;

    // Fixed field widths
    localparam int VAL_W  = 16;
    localparam int BEST_W = 48;
    // Exact candidate width: 64 * (2^16 - 1) + (2^48 - 1) < 2^49
    localparam int ACC_W  = BEST_W + 1;
    localparam int CFG_W  = 5;
    // Wide enough to hold MAX_PART at its top value of 64
    localparam int LEN_W  = 7;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN
    } state_t;

    // Window load strobes shared by all cells
    typedef struct packed {
        logic val_load;
        logic best_load;
    } win_ctrl_t;

    // Partial result that walks down the chain, one cell per cycle
    typedef struct packed {
        logic              valid;
        logic [VAL_W-1:0]  run_max;
        logic [ACC_W-1:0]  acc;
    } token_t;

endpackage

FILE: hw/rtl/pmsdp_cell.sv
`timescale 1ns / 1ps
module pmsdp_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  pmsdp_pkg::win_ctrl_t             ctrl,
    input  logic [pmsdp_pkg::VAL_W-1:0]      val_in,
    input  logic [pmsdp_pkg::BEST_W-1:0]     best_in,
    output logic [pmsdp_pkg::VAL_W-1:0]      val_out,
    output logic [pmsdp_pkg::BEST_W-1:0]     best_out,
    input  logic [CNT_W-1:0]                 span,
    input  pmsdp_pkg::token_t                tok_in,
    output pmsdp_pkg::token_t                tok_out
);
    import pmsdp_pkg::*;

    // Piece length that this cell scores: the piece covers entries 0..IDX
    localparam logic [LEN_W-1:0] PIECE_LEN = LEN_W'(IDX + 1);
    localparam logic [CNT_W-1:0] CELL_IDX  = CNT_W'(IDX);

    logic [VAL_W-1:0]  val_reg;
    logic [BEST_W-1:0] best_reg;
    token_t            tok_reg;
    token_t            tok_next;

    logic              active;
    logic [VAL_W-1:0]  run_max;
    logic [ACC_W-1:0]  cand;

    assign val_out  = val_reg;
    assign best_out = best_reg;
    assign tok_out  = tok_reg;

    // Score this piece length and fold it into the running best
    always_comb begin
        active  = (CELL_IDX < span);
        run_max = tok_in.run_max;
        if (active && (val_reg > tok_in.run_max)) begin
            run_max = val_reg;
        end
        cand = ACC_W'(run_max) * ACC_W'(PIECE_LEN) + ACC_W'(best_reg);
        tok_next.valid   = tok_in.valid;
        tok_next.run_max = run_max;
        tok_next.acc     = tok_in.acc;
        if (active && (cand > tok_in.acc)) begin
            tok_next.acc = cand;
        end
    end

    // Hold window entries; shift on load strobes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            val_reg  <= '0;
            best_reg <= '0;
        end else begin
            if (ctrl.val_load) begin
                val_reg <= val_in;
            end
            if (ctrl.best_load) begin
                best_reg <= best_in;
            end
        end
    end

    // Advance the token to the next cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg.valid <= tok_next.valid;
        end
        if (tok_in.valid) begin
            tok_reg.run_max <= tok_next.run_max;
            tok_reg.acc     <= tok_next.acc;
        end
    end

endmodule

FILE: hw/rtl/partition_max_sum_dp_top.sv
`timescale 1ns / 1ps
// From an input transfer, start_reg launches a token that walks the chain of MAX_PART cells,
// one cell per cycle; its sum is captured in res_reg, then loaded into the output register.
// A new item is taken only after the last one is through; s_tready is high only when no item
// is in the chain and the previous result has been moved to the output register.
// Reset (aresetn low, synchronous): windows and item count clear, piece length is 1.
module partition_max_sum_dp_top #(
    parameter int MAX_PART   = 16,
    parameter int VALUE_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_wen,
    input  logic [pmsdp_pkg::CFG_W-1:0]       cfg_wdata,   // max_part_len
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [pmsdp_pkg::VAL_W-1:0]       s_tdata,     // [15:0] elem_value
    input  logic                              s_tuser,     // [0] first_item
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pmsdp_pkg::BEST_W-1:0]      m_tdata      // [47:0] prefix_best
);
    import pmsdp_pkg::*;

    localparam int CNT_W = $clog2(MAX_PART + 1);
    localparam int VW    = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W;
    localparam logic [VAL_W-1:0] VAL_MASK = VAL_W'((64'd1 << VW) - 64'd1);
    localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_PART);

    state_t              state_reg, state_next;
    logic [CFG_W-1:0]    part_len_reg;
    logic [CNT_W-1:0]    items_seen_reg, items_seen_next;
    logic [CNT_W-1:0]    span_reg, span_next;
    logic                start_reg;
    logic [ACC_W-1:0]    res_reg;
    logic                m_tvalid_reg;
    logic [BEST_W-1:0]   m_tdata_reg;

    logic                in_xfer;
    logic                drain_go;
    win_ctrl_t           ctrl;
    logic [LEN_W-1:0]    k_len;
    logic [LEN_W-1:0]    avail;
    logic [BEST_W-1:0]   res_sat;

    logic [VAL_W-1:0]    val_w   [MAX_PART];
    logic [BEST_W-1:0]   best_w  [MAX_PART];
    logic [VAL_W-1:0]    val_in  [MAX_PART];
    logic [BEST_W-1:0]   best_in [MAX_PART];
    token_t              tok_w   [MAX_PART+1];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign in_xfer  = s_tvalid && s_tready;

    // Span of this item: clamp K, clamp available history
    always_comb begin
        k_len = LEN_W'(part_len_reg);
        if (k_len == '0) begin
            k_len = LEN_W'(1);
        end
        if (k_len > MAX_LEN) begin
            k_len = MAX_LEN;
        end
        avail = (s_tuser ? LEN_W'(0) : LEN_W'(items_seen_reg)) + LEN_W'(1);
        if (avail > MAX_LEN) begin
            avail = MAX_LEN;
        end
        items_seen_next = items_seen_reg;
        span_next       = span_reg;
        if (in_xfer) begin
            items_seen_next = CNT_W'(avail);
            span_next       = CNT_W'((k_len < avail) ? k_len : avail);
        end
    end

    // Saturate the finished sum
    assign res_sat = res_reg[ACC_W-1] ? {BEST_W{1'b1}} : res_reg[BEST_W-1:0];

    // Sequencer: next state and strobes
    always_comb begin
        state_next = state_reg;
        drain_go   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (tok_w[MAX_PART].valid) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    drain_go   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        ctrl.val_load  = in_xfer;
        ctrl.best_load = (in_xfer && s_tuser) || drain_go;
    end

    // Window shift inputs: new item enters at cell 0, a first item clears the rest
    always_comb begin
        for (int i = 0; i < MAX_PART; i++) begin
            if (i == 0) begin
                val_in[i]  = s_tdata & VAL_MASK;
                best_in[i] = drain_go ? res_sat : '0;
            end else begin
                val_in[i]  = s_tuser ? '0 : val_w[i-1];
                best_in[i] = drain_go ? best_w[i-1] : '0;
            end
        end
    end

    // Inject a fresh token into cell 0
    always_comb begin
        tok_w[0].valid   = start_reg;
        tok_w[0].run_max = '0;
        tok_w[0].acc     = '0;
    end

    // Chain of cells, one per window entry
    for (genvar g = 0; g < MAX_PART; g++) begin : g_cell
        pmsdp_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .val_in   (val_in[g]),
            .best_in  (best_in[g]),
            .val_out  (val_w[g]),
            .best_out (best_w[g]),
            .span     (span_reg),
            .tok_in   (tok_w[g]),
            .tok_out  (tok_w[g+1])
        );
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            part_len_reg   <= CFG_W'(1);
            items_seen_reg <= '0;
            span_reg       <= '0;
            start_reg      <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            items_seen_reg <= items_seen_next;
            span_reg       <= span_next;
            start_reg      <= in_xfer;
            if (cfg_wen) begin
                part_len_reg <= cfg_wdata;
            end
            if (drain_go) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Capture the chain result; load the output register
    always_ff @(posedge aclk) begin
        if (tok_w[MAX_PART].valid) begin
            res_reg <= tok_w[MAX_PART].acc;
        end
        if (drain_go) begin
            m_tdata_reg <= res_sat;
        end
    end

endmodule
